### rtl/tvf_pkg.sv
// ----------------------------------------------------------------------------
// tvf_pkg
// Shared types and constants of the TSDF voxel fusion update block.
// ----------------------------------------------------------------------------
package tvf_pkg;

  // Register indexes of the configuration port, taken from paddr[4:2].
  localparam logic [2:0] REG_TRUNC     = 3'd0;
  localparam logic [2:0] REG_MIN_DEPTH = 3'd1;
  localparam logic [2:0] REG_MAX_DEPTH = 3'd2;
  localparam logic [2:0] REG_MAX_WGT   = 3'd3;
  localparam logic [2:0] REG_CONF_FLR  = 3'd4;
  localparam logic [2:0] REG_POSE_CONF = 3'd5;
  localparam logic [2:0] REG_DEPTH_SCL = 3'd6;

  // Entries of the queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic signed [31:0] voxel_depth;
    logic [31:0]        observed_raw_depth;
    logic               depth_valid;
    logic [7:0]         pixel_confidence;
    logic signed [15:0] old_distance;
    logic [31:0]        old_weight;
    logic [47:0]        old_color;
    logic [47:0]        sample_color;
    logic [31:0]        old_count;
  } in_t;

  typedef struct packed {
    logic               updated;
    logic signed [15:0] new_distance;
    logic [31:0]        new_weight;
    logic [47:0]        new_color;
    logic [31:0]        new_count;
  } out_t;

  typedef struct packed {
    logic [31:0] truncation_distance;
    logic [31:0] min_depth;
    logic [31:0] max_depth;
    logic [31:0] max_weight;
    logic [7:0]  confidence_floor;
    logic [16:0] pose_confidence;
    logic [31:0] depth_scale;
  } cfg_t;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic        ok;
    logic        neg;
    logic [31:0] mag;
    logic [15:0] od;
    logic [31:0] ow;
    logic [47:0] ocol;
    logic [47:0] scol;
    logic [31:0] ocnt;
    logic [31:0] comb;
    logic [31:0] con;
    logic [31:0] ret;
  } job_t;

  // Side data that travels with the distance-averaging divider.
  typedef struct packed {
    logic        ok;
    logic        dneg;
    logic [15:0] od;
    logic [31:0] ow;
    logic [47:0] ocol;
    logic [31:0] ocnt;
    logic [31:0] comb;
  } avg_tag_t;

endpackage

### rtl/tsdf_voxel_fusion_update.sv
// ----------------------------------------------------------------------------
// tsdf_voxel_fusion_update
// TSDF weighted-average fusion of one voxel with one depth observation.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Handshake
//   -------   ----------------------------   ---------------------------------
//   input     start, busy, in_item           taken when start && !busy
//   result    out_valid, out_result          one-cycle strobe, no back-pressure
//   config    psel..pready, paddr, pwdata     APB write, pready tied high
//
// A new request can be taken every clock cycle while busy is low. Each
// request passes 37 register stages, the first loaded at the edge that takes
// it: two front stages, the queue entry, a 16-stage pipelined divider for
// the normalized distance, one multiply stage, a second 16-stage divider
// bank for the weighted averages and the output register. Reset (rst_n low,
// synchronous) restores the register defaults and empties every pipeline.
// Since the receiver cannot stall, the back end drains the queue every
// cycle and busy stays low in practice; it only guards the queue against
// overflow.
//
module tsdf_voxel_fusion_update #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tvf_pkg::in_t         in_item,
  output logic                 out_valid,
  output tvf_pkg::out_t        out_result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  tvf_pkg::cfg_t             cfg_r;
  logic                      wr_en;
  logic [2:0]                ridx;
  logic                      acc;
  logic [1:0]                inflight;
  logic                      push;
  tvf_pkg::job_t             fjob;
  tvf_pkg::job_t             qjob;
  logic                      qempty;
  logic [tvf_pkg::QAW:0]     qcnt;
  logic [31:0]               trunc;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign ridx   = paddr[4:2];

  // Configuration registers; writes to addresses past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.truncation_distance <= 32'd65536;
      cfg_r.min_depth           <= 32'd0;
      cfg_r.max_depth           <= 32'd655360;
      cfg_r.max_weight          <= 32'd6553600;
      cfg_r.confidence_floor    <= 8'd0;
      cfg_r.pose_confidence     <= 17'd65536;
      cfg_r.depth_scale         <= 32'd65536;
    end else if (wr_en) begin
      unique case (ridx)
        tvf_pkg::REG_TRUNC:     cfg_r.truncation_distance <= pwdata;
        tvf_pkg::REG_MIN_DEPTH: cfg_r.min_depth           <= pwdata;
        tvf_pkg::REG_MAX_DEPTH: cfg_r.max_depth           <= pwdata;
        tvf_pkg::REG_MAX_WGT:   cfg_r.max_weight          <= pwdata;
        tvf_pkg::REG_CONF_FLR:  cfg_r.confidence_floor    <= pwdata[7:0];
        tvf_pkg::REG_POSE_CONF: cfg_r.pose_confidence     <= pwdata[16:0];
        tvf_pkg::REG_DEPTH_SCL: cfg_r.depth_scale         <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      tvf_pkg::REG_TRUNC:     prdata = cfg_r.truncation_distance;
      tvf_pkg::REG_MIN_DEPTH: prdata = cfg_r.min_depth;
      tvf_pkg::REG_MAX_DEPTH: prdata = cfg_r.max_depth;
      tvf_pkg::REG_MAX_WGT:   prdata = cfg_r.max_weight;
      tvf_pkg::REG_CONF_FLR:  prdata = {24'b0, cfg_r.confidence_floor};
      tvf_pkg::REG_POSE_CONF: prdata = {15'b0, cfg_r.pose_confidence};
      tvf_pkg::REG_DEPTH_SCL: prdata = cfg_r.depth_scale;
      default:                prdata = 32'b0;
    endcase
  end

  // Requests still in the front stages are counted against queue space, so
  // anything taken is sure to find a free entry.
  assign busy  = (3'(qcnt) + 3'(inflight)) >= 3'(tvf_pkg::QDEPTH);
  assign acc   = start && !busy;
  // A zero truncation band behaves as one LSB.
  assign trunc = (cfg_r.truncation_distance == '0) ? 32'd1 : cfg_r.truncation_distance;

  tvf_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .item     (in_item),
    .cfg      (cfg_r),
    .inflight (inflight),
    .push     (push),
    .job      (fjob)
  );

  tvf_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (fjob),
    .pop   (!qempty),
    .rdata (qjob),
    .empty (qempty),
    .cnt   (qcnt)
  );

  tvf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld        (!qempty),
    .job        (qjob),
    .trunc      (trunc),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

### rtl/tvf_div.sv
// ----------------------------------------------------------------------------
// tvf_div
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module tvf_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 16,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic [TW-1:0] out_tag
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic [W-1:0]  rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [TW-1:0] tag_r [QW];
  logic          vld_r [QW];

  // The quotient is known to fit in QW bits, so each stage only has to
  // test the divisor shifted to its own bit position.
  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [W-1:0]  rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [TW-1:0] tag_in;
    logic          vld_in;
    logic [W-1:0]  sh;
    logic [W-1:0]  rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (s == 0) begin : g_first
      assign rem_in = W'(in_num);
      assign den_in = in_den;
      assign quo_in = '0;
      assign tag_in = in_tag;
      assign vld_in = in_vld;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
      assign tag_in = tag_r[s-1];
      assign vld_in = vld_r[s-1];
    end

    always_comb begin
      sh      = W'(den_in) << (QW - 1 - s);
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      if (rem_in >= sh) begin
        rem_nxt = rem_in - sh;
        quo_nxt[QW-1-s] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
      rem_r[s] <= rem_nxt;
      den_r[s] <= den_in;
      quo_r[s] <= quo_nxt;
      tag_r[s] <= tag_in;
    end
  end

  assign out_vld = vld_r[QW-1];
  assign out_quo = quo_r[QW-1];
  assign out_tag = tag_r[QW-1];

endmodule

### rtl/tvf_front.sv
// ----------------------------------------------------------------------------
// tvf_front
// Accepts requests, scales the depth, applies the rejection tests and works
// out the sample weight and the combined weight.
// ----------------------------------------------------------------------------
module tvf_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  tvf_pkg::in_t       item,
  input  tvf_pkg::cfg_t      cfg,
  output logic [1:0]         inflight,
  output logic               push,
  output tvf_pkg::job_t      job
);

  // floor(y / 255) == (y * Recip255) >> 39 for any 32-bit y.
  localparam logic [31:0] Recip255 = 32'h80808081;
  localparam int          RecipSh  = 39;

  logic               va_r, vb_r;
  tvf_pkg::in_t       ia_r, ib_r;
  logic [63:0]        rawp_r;
  logic [24:0]        cp_r;

  logic               okb_r;
  logic               negb_r;
  logic [31:0]        magb_r;
  logic [63:0]        m_r;

  logic [16:0]        pose;
  logic [63:0]        obs;
  logic signed [65:0] sd;
  logic signed [65:0] tr_s;
  logic               ok_b;
  logic [31:0]        trunc;
  logic [63:0]        ywide;
  logic [31:0]        y;
  logic [63:0]        m_nxt;
  logic [65:0]        sdc;

  logic [24:0]        sw;
  logic [31:0]        cap;
  logic [32:0]        sum;
  logic [31:0]        comb;
  logic [31:0]        con;

  assign pose  = (cfg.pose_confidence > 17'h10000) ? 17'h10000 : cfg.pose_confidence;
  assign trunc = (cfg.truncation_distance == '0) ? 32'd1 : cfg.truncation_distance;

  // Second stage: depth tests, signed distance and the weight product.
  always_comb begin
    obs  = rawp_r >> FRAC_BITS;
    sd   = $signed({2'b00, obs}) - $signed({{34{ia_r.voxel_depth[31]}}, ia_r.voxel_depth});
    tr_s = $signed({34'b0, trunc});
    ok_b = 1'b1;
    if ($signed({ia_r.voxel_depth[31], ia_r.voxel_depth}) <= $signed({1'b0, cfg.min_depth}))
      ok_b = 1'b0;
    if (!ia_r.depth_valid)
      ok_b = 1'b0;
    if (obs < {32'b0, cfg.min_depth} || obs > {32'b0, cfg.max_depth})
      ok_b = 1'b0;
    if (ia_r.pixel_confidence < cfg.confidence_floor)
      ok_b = 1'b0;
    if (sd < -tr_s)
      ok_b = 1'b0;
    sdc   = (sd > tr_s) ? tr_s : sd;
    ywide = (64'(cp_r) << FRAC_BITS) >> 16;
    y     = ywide[31:0];
    m_nxt = y * Recip255;
  end

  // Third stage: sample weight and weight split, then into the queue.
  always_comb begin
    sw   = m_r[RecipSh +: 25];
    cap  = (cfg.max_weight == '0) ? 32'd1 : cfg.max_weight;
    sum  = {1'b0, ib_r.old_weight} + 33'(sw);
    comb = (sum > {1'b0, cap}) ? cap : sum[31:0];
    con  = (32'(sw) < comb) ? 32'(sw) : comb;

    job      = '0;
    job.ok   = okb_r && (sw != '0);
    job.neg  = negb_r;
    job.mag  = magb_r;
    job.od   = ib_r.old_distance;
    job.ow   = ib_r.old_weight;
    job.ocol = ib_r.old_color;
    job.scol = ib_r.sample_color;
    job.ocnt = ib_r.old_count;
    job.comb = comb;
    job.con  = con;
    job.ret  = comb - con;
  end

  assign push     = vb_r;
  assign inflight = {1'b0, va_r} + {1'b0, vb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= acc;
      vb_r <= va_r;
    end
    ia_r   <= item;
    rawp_r <= 64'(item.observed_raw_depth) * 64'(cfg.depth_scale);
    cp_r   <= 25'(item.pixel_confidence) * 25'(pose);
    ib_r   <= ia_r;
    okb_r  <= ok_b;
    negb_r <= sdc[65];
    magb_r <= sdc[65] ? 32'(-sdc) : sdc[31:0];
    m_r    <= m_nxt;
  end

endmodule

### rtl/tvf_fifo.sv
// ----------------------------------------------------------------------------
// tvf_fifo
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module tvf_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  tvf_pkg::job_t              wdata,
  input  logic                       pop,
  output tvf_pkg::job_t              rdata,
  output logic                       empty,
  output logic [tvf_pkg::QAW:0]      cnt
);

  tvf_pkg::job_t             mem [tvf_pkg::QDEPTH];
  logic [tvf_pkg::QAW-1:0]   wp_r, wp_nxt;
  logic [tvf_pkg::QAW-1:0]   rp_r, rp_nxt;
  logic [tvf_pkg::QAW:0]     cnt_r, cnt_nxt;
  logic                      do_pop;

  assign do_pop = pop && (cnt_r != '0);
  assign empty  = (cnt_r == '0);
  assign cnt    = cnt_r;
  assign rdata  = mem[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + {{tvf_pkg::QAW{1'b0}}, push} - {{tvf_pkg::QAW{1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem[wp_r] <= wdata;
    end
  end

endmodule

### rtl/tvf_back.sv
// ----------------------------------------------------------------------------
// tvf_back
// Carries out the fusion: distance normalization, weighted averages and the
// registered result.
// ----------------------------------------------------------------------------
module tvf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld,
  input  tvf_pkg::job_t  job,
  input  logic [31:0]    trunc,
  output logic           out_valid,
  output tvf_pkg::out_t  out_result
);

  localparam int JW = $bits(tvf_pkg::job_t);
  localparam int AW = $bits(tvf_pkg::avg_tag_t);

  logic                 n_vld;
  logic [15:0]          n_quo;
  logic [JW-1:0]        n_tagb;
  tvf_pkg::job_t        nj;
  logic signed [16:0]   nd;

  logic signed [48:0]   dprod_o;
  logic signed [49:0]   dprod_n;
  logic [47:0]          cprod_o [3];
  logic [47:0]          cprod_s [3];
  logic signed [51:0]   dsum;
  logic                 m_vld_r;
  logic [50:0]          dmag_r;
  logic [48:0]          cnum_r [3];
  tvf_pkg::avg_tag_t    mtag_r;

  logic                 a_vld;
  logic [15:0]          a_dq;
  logic [AW-1:0]        a_tagb;
  tvf_pkg::avg_tag_t    at;
  logic [15:0]          a_cq [3];
  logic                 c_vld [3];
  logic [15:0]          avg_dist;

  logic                 ov_r;
  tvf_pkg::out_t        or_r, or_nxt;

  // Normalized distance: |sd| * 2^15 / truncation.
  tvf_div #(.NW(47), .DW(32), .QW(16), .TW(JW)) u_ndiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld),
    .in_num  ({job.mag, 15'b0}),
    .in_den  (trunc),
    .in_tag  (JW'(job)),
    .out_vld (n_vld),
    .out_quo (n_quo),
    .out_tag (n_tagb)
  );

  assign nj = tvf_pkg::job_t'(n_tagb);

  always_comb begin
    if (nj.neg) begin
      nd = -$signed({1'b0, n_quo});
    end else if (n_quo[15]) begin
      nd = 17'sd32767;
    end else begin
      nd = $signed({1'b0, n_quo});
    end
    // Products are formed at full width before they are summed.
    dprod_o = $signed(nj.od) * $signed({1'b0, nj.ret});
    dprod_n = nd * $signed({1'b0, nj.con});
    dsum    = 52'(dprod_o) + 52'(dprod_n);
    for (int c = 0; c < 3; c++) begin
      cprod_o[c] = nj.ocol[16*c +: 16] * nj.ret;
      cprod_s[c] = nj.scol[16*c +: 16] * nj.con;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= n_vld;
    end
    dmag_r      <= dsum[51] ? 51'(-dsum) : dsum[50:0];
    mtag_r.ok   <= nj.ok;
    mtag_r.dneg <= dsum[51];
    mtag_r.od   <= nj.od;
    mtag_r.ow   <= nj.ow;
    mtag_r.ocol <= nj.ocol;
    mtag_r.ocnt <= nj.ocnt;
    mtag_r.comb <= nj.comb;
    for (int c = 0; c < 3; c++) begin
      cnum_r[c] <= 49'(cprod_o[c]) + 49'(cprod_s[c]);
    end
  end

  tvf_div #(.NW(51), .DW(32), .QW(16), .TW(AW)) u_ddiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (m_vld_r),
    .in_num  (dmag_r),
    .in_den  (mtag_r.comb),
    .in_tag  (AW'(mtag_r)),
    .out_vld (a_vld),
    .out_quo (a_dq),
    .out_tag (a_tagb)
  );

  for (genvar c = 0; c < 3; c++) begin : g_col
    tvf_div #(.NW(49), .DW(32), .QW(16), .TW(1)) u_cdiv (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (m_vld_r),
      .in_num  (cnum_r[c]),
      .in_den  (mtag_r.comb),
      .in_tag  (1'b0),
      .out_vld (c_vld[c]),
      .out_quo (a_cq[c]),
      .out_tag ()
    );
  end

  assign at       = tvf_pkg::avg_tag_t'(a_tagb);
  assign avg_dist = at.dneg ? 16'(-a_dq) : a_dq;

  always_comb begin
    or_nxt = '0;
    if (at.ok) begin
      or_nxt.updated      = 1'b1;
      or_nxt.new_distance = avg_dist;
      or_nxt.new_weight   = at.comb;
      or_nxt.new_color    = {a_cq[2], a_cq[1], a_cq[0]};
      or_nxt.new_count    = (at.ocnt == 32'hFFFF_FFFF) ? at.ocnt : at.ocnt + 32'd1;
    end else begin
      or_nxt.new_distance = at.od;
      or_nxt.new_weight   = at.ow;
      or_nxt.new_color    = at.ocol;
      or_nxt.new_count    = at.ocnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= a_vld && c_vld[0] && c_vld[1] && c_vld[2];
    end
    or_r <= or_nxt;
  end

  assign out_valid  = ov_r;
  assign out_result = or_r;

endmodule
